@@ hw/rtl/ttip_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_pkg - shared types and constants for the text-to-integer parser
// Word formats, parser state, phase and status codes, character helpers.
// ----------------------------------------------------------------------------
package ttip_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int BASE_W  = 6;
  // accumulator * base + digit never exceeds this width
  localparam int PROD_W  = VALUE_W + BASE_W;

  localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE     = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET   = 6'd10;
  // above every legal base, so "digit >= base" rejects it
  localparam logic [BASE_W-1:0] DIGIT_NONE   = 6'd63;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_HEXMARK,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_CONV  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_BASE = 2'd3
  } status_t;

  typedef struct packed {
    logic       first;
    logic [7:0] ch;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic [COUNT_W-1:0]        consumed_count;
  } out_word_t;

  typedef struct packed {
    phase_t             phase;
    logic               negative;
    logic [VALUE_W-1:0] acc;
    logic [BASE_W-1:0]  ebase;
    logic               saw_digit;
    logic               overflowed;
    logic [COUNT_W-1:0] count;
  } parse_state_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // digit value 0..35, DIGIT_NONE for anything else
  function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - (CH_LO_A - LETTER_OFS);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - (CH_UP_A - LETTER_OFS);
    end else begin
      d = {2'b00, DIGIT_NONE};
    end
    return d[BASE_W-1:0];
  endfunction

endpackage

@@ hw/rtl/text_to_integer_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_integer_parser_top - streaming strtol-style number parser
// Input register, one-byte parser step, result register.
// ----------------------------------------------------------------------------
// Takes one string byte per word and returns one result word when the byte
// ending the number arrives (or at once on an invalid base). A byte is taken
// every cycle unless the input side stalls; a result passes through the input
// register, then the result register. The per-byte limit is the digit
// multiply-add and saturation compare in ttip_step. The input side stalls
// only while the result register is full and not taken.
// cfg_wdata is the radix (2..36, 0 = auto) and is latched at each first byte;
// write it only while the parser is idle.
module text_to_integer_parser_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ttip_pkg::in_word_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ttip_pkg::out_word_t         out_data,
  input  logic                        cfg_we,
  input  logic [ttip_pkg::BASE_W-1:0] cfg_wdata
);

  logic                        s1_valid_r, s1_valid_nxt;
  ttip_pkg::in_word_t          s1_word_r;
  logic                        out_valid_r, out_valid_nxt;
  ttip_pkg::out_word_t         out_word_r;
  ttip_pkg::parse_state_t      st_r, st_nxt;
  logic [ttip_pkg::BASE_W-1:0] base_r;
  logic                        s1_fire;
  logic                        step_emit;
  ttip_pkg::out_word_t         step_result;

  ttip_step u_step (
    .st          (st_r),
    .word        (s1_word_r),
    .number_base (base_r),
    .st_nxt      (st_nxt),
    .emit        (step_emit),
    .result      (step_result)
  );

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_comb begin
    s1_valid_nxt  = (in_valid && in_ready) ? 1'b1 : (s1_valid_r && !s1_fire);
    out_valid_nxt = s1_fire ? step_emit : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= ttip_pkg::BASE_RESET;
      st_r        <= '{phase: ttip_pkg::PH_IDLE, negative: 1'b0, acc: '0, ebase: '0,
                       saw_digit: 1'b0, overflowed: 1'b0, count: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) base_r <= cfg_wdata;
      if (s1_fire) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_word_r <= in_data;
    if (s1_fire && step_emit) out_word_r <= step_result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && step_emit) |=> (st_r.phase == ttip_pkg::PH_DONE))
    else $error("parser not in done phase after a result");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.acc <= ({1'b1, {(ttip_pkg::VALUE_W-1){1'b0}}}))
    else $error("accumulator beyond signed limit");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.status == ttip_pkg::ST_BAD_BASE ||
                     out_word_r.status == ttip_pkg::ST_NO_CONV))
      |-> (out_word_r.value == '0 && out_word_r.consumed_count == '0))
    else $error("failed conversion with nonzero value or count");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full result register");

endmodule

@@ hw/rtl/ttip_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_step - one-byte parser step
// Next parser state and optional result for the current byte. One
// multiply-add by the base plus a limit compare on the digit path.
// ----------------------------------------------------------------------------
module ttip_step (
  input  ttip_pkg::parse_state_t       st,
  input  ttip_pkg::in_word_t           word,
  input  logic [ttip_pkg::BASE_W-1:0]  number_base,
  output ttip_pkg::parse_state_t       st_nxt,
  output logic                         emit,
  output ttip_pkg::out_word_t          result
);

  localparam int VW = ttip_pkg::VALUE_W;
  localparam int CW = ttip_pkg::COUNT_W;
  localparam int PW = ttip_pkg::PROD_W;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (c == {CW{1'b1}}) ? c : c + CW'(1);
  endfunction

  ttip_pkg::parse_state_t    n;
  ttip_pkg::phase_t          ph;
  logic [ttip_pkg::BASE_W-1:0] eb;
  logic [ttip_pkg::BASE_W-1:0] dig;
  logic                      do_signed;
  logic                      do_digit;
  logic [PW-1:0]             prod;
  logic [PW-1:0]             limit;

  always_comb begin
    n         = st;
    ph        = st.phase;
    eb        = st.ebase;
    emit      = 1'b0;
    result    = '{value: '0, status: ttip_pkg::ST_OK, consumed_count: '0};
    do_signed = 1'b0;
    do_digit  = 1'b0;
    dig       = ttip_pkg::digit_of(word.ch);
    prod      = '0;
    limit     = '0;

    if (word.first) begin
      n.negative   = 1'b0;
      n.acc        = '0;
      n.saw_digit  = 1'b0;
      n.overflowed = 1'b0;
      n.count      = '0;
      eb           = number_base;
      ph           = ttip_pkg::PH_SPACE;
      if (eb == ttip_pkg::BASE_ONE || eb > ttip_pkg::BASE_MAX) begin
        emit          = 1'b1;
        result.status = ttip_pkg::ST_BAD_BASE;
        ph            = ttip_pkg::PH_DONE;
      end
    end

    // bad base ends the string at once; PH_DONE then ignores this byte
    if (!emit) begin
      case (ph)
        ttip_pkg::PH_SPACE: begin
          if (ttip_pkg::is_space(word.ch)) begin
            n.count = sat_inc(n.count);
            n.phase = ttip_pkg::PH_SPACE;
          end else if (word.ch == ttip_pkg::CH_PLUS || word.ch == ttip_pkg::CH_MINUS) begin
            n.negative = (word.ch == ttip_pkg::CH_MINUS);
            n.count    = sat_inc(n.count);
            n.phase    = ttip_pkg::PH_SIGNED;
          end else begin
            do_signed = 1'b1;
          end
        end
        ttip_pkg::PH_SIGNED: do_signed = 1'b1;
        ttip_pkg::PH_ZERO: begin
          if (word.ch == ttip_pkg::CH_LO_X || word.ch == ttip_pkg::CH_UP_X) begin
            eb      = ttip_pkg::BASE_HEX;
            n.count = sat_inc(n.count);
            n.phase = ttip_pkg::PH_HEXMARK;
          end else begin
            if (eb == ttip_pkg::BASE_AUTO) eb = ttip_pkg::BASE_OCT;
            do_digit = 1'b1;
          end
        end
        ttip_pkg::PH_HEXMARK: begin
          if (dig < ttip_pkg::BASE_HEX) begin
            do_digit = 1'b1;
          end else begin
            // "0x" with no hex digit: only the '0' converts
            emit                  = 1'b1;
            result.status         = ttip_pkg::ST_OK;
            result.consumed_count = (n.count == {CW{1'b1}}) ? n.count : n.count - CW'(1);
            n.phase               = ttip_pkg::PH_DONE;
          end
        end
        ttip_pkg::PH_DIGITS: do_digit = 1'b1;
        default: n.phase = ph;
      endcase

      if (do_signed) begin
        if (word.ch == ttip_pkg::CH_ZERO &&
            (eb == ttip_pkg::BASE_AUTO || eb == ttip_pkg::BASE_HEX)) begin
          n.saw_digit = 1'b1;
          n.count     = sat_inc(n.count);
          n.phase     = ttip_pkg::PH_ZERO;
        end else begin
          if (eb == ttip_pkg::BASE_AUTO) eb = ttip_pkg::BASE_DEC;
          do_digit = 1'b1;
        end
      end

      if (do_digit) begin
        if (dig >= eb) begin
          emit    = 1'b1;
          n.phase = ttip_pkg::PH_DONE;
          if (!n.saw_digit) begin
            result.status = ttip_pkg::ST_NO_CONV;
          end else if (n.overflowed) begin
            result.status         = ttip_pkg::ST_OVERFLOW;
            result.value          = n.negative ? $signed({1'b1, {(VW-1){1'b0}}})
                                               : $signed({1'b0, {(VW-1){1'b1}}});
            result.consumed_count = n.count;
          end else begin
            result.status         = ttip_pkg::ST_OK;
            result.value          = n.negative ? $signed(-n.acc) : $signed(n.acc);
            result.consumed_count = n.count;
          end
        end else begin
          // acc > (limit - d) / base  <=>  acc * base + d > limit
          prod  = PW'(n.acc) * PW'(eb) + PW'(dig);
          limit = (PW'(1) << (VW - 1)) - PW'(!n.negative);
          n.saw_digit = 1'b1;
          if (n.overflowed || prod > limit) begin
            n.overflowed = 1'b1;
          end else begin
            n.acc = prod[VW-1:0];
          end
          n.count = sat_inc(n.count);
          n.phase = ttip_pkg::PH_DIGITS;
        end
      end
    end else begin
      n.phase = ph;
    end

    n.ebase = eb;
    st_nxt  = n;
  end

endmodule
